// ===== sv/plk_pkg.sv =====
`default_nettype none

package plk_pkg;

  // Defaults for the top-level parameters.
  localparam int PIN_DIGITS_DEF       = 4;
  localparam int TICKS_PER_SECOND_DEF = 1000;

  // Width of the tick count handed to the seconds stage.
  localparam int SECS_ARG_W = 17;
  localparam int SECS_OUT_W = 7;

  // Register reset values.
  localparam logic [15:0] PIN_CODE_RST      = 16'h1234;
  localparam logic [3:0]  FAILURE_LIMIT_RST = 4'd3;
  localparam logic [15:0] LOCK_TICKS_RST    = 16'd10000;
  localparam logic [15:0] BOOT_TICKS_RST    = 16'd2000;

  // Configuration register indexes.
  localparam logic [1:0] REG_PIN_CODE      = 2'd0;
  localparam logic [1:0] REG_FAILURE_LIMIT = 2'd1;
  localparam logic [1:0] REG_LOCK_TICKS    = 2'd2;
  localparam logic [1:0] REG_BOOT_TICKS    = 2'd3;

  // Input commands.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_DIGIT = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_ENTER = 2'd3;

  // Result notes.
  localparam logic [2:0] NOTE_NONE   = 3'd0;
  localparam logic [2:0] NOTE_DIGIT  = 3'd1;
  localparam logic [2:0] NOTE_NEED   = 3'd2;
  localparam logic [2:0] NOTE_WRONG  = 3'd3;
  localparam logic [2:0] NOTE_CLEAR  = 3'd4;
  localparam logic [2:0] NOTE_OK     = 3'd5;
  localparam logic [2:0] NOTE_LOCKED = 3'd6;

  localparam logic [3:0] WRONG_MAX = 4'hF;

  typedef enum logic [1:0] {
    MODE_BOOT   = 2'd0,
    MODE_LOGIN  = 2'd1,
    MODE_LOCKED = 2'd2,
    MODE_OPEN   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] digit;
  } in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] entered_count;
    logic [3:0] failure_count;
    logic [2:0] note;
    logic [6:0] seconds_left;
  } out_t;

  typedef struct packed {
    logic [15:0] pin_code;
    logic [3:0]  failure_limit;
    logic [15:0] lock_ticks;
    logic [15:0] boot_ticks;
  } cfg_t;

  // Boot delay write, seen by the core in the same cycle.
  typedef struct packed {
    logic        load;
    logic [15:0] value;
  } boot_wr_t;

  // Result fields before the seconds conversion.
  typedef struct packed {
    logic [1:0]            mode;
    logic [2:0]            entered_count;
    logic [3:0]            failure_count;
    logic [2:0]            note;
    logic [SECS_ARG_W-1:0] secs_arg;
  } st1_t;

endpackage

`default_nettype wire

// ===== sv/pin_entry_lockout_controller.sv =====
// Pipeline: a transaction passes the input register, the state update into the result
// register and the seconds multiply register before its result is valid and can be
// taken. Throughput: one transaction per cycle while out_ready does not stall the output;
// the state update is a loop closed through the lock state registers alone.
// Reset (rst, synchronous): boot mode, no digits, no failures, boot countdown at
// the boot_ticks default, configuration registers at their defaults, pipeline empty.
`default_nettype none

module pin_entry_lockout_controller #(
  parameter int PIN_DIGITS       = plk_pkg::PIN_DIGITS_DEF,
  parameter int TICKS_PER_SECOND = plk_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire plk_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output plk_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);

  plk_pkg::cfg_t     cfg;
  plk_pkg::boot_wr_t boot_wr;
  plk_pkg::st1_t     s1;
  logic              s1_valid;
  logic              s1_ready;

  assign cfg_ready = 1'b1;

  plk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .boot_wr   (boot_wr)
  );

  plk_core #(
    .PIN_DIGITS (PIN_DIGITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .boot_wr  (boot_wr),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  plk_secs #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_secs (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1        (s1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/plk_cfg.sv =====
`default_nettype none

module plk_cfg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  output plk_pkg::cfg_t             cfg,
  output plk_pkg::boot_wr_t         boot_wr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_code      <= plk_pkg::PIN_CODE_RST;
      cfg.failure_limit <= plk_pkg::FAILURE_LIMIT_RST;
      cfg.lock_ticks    <= plk_pkg::LOCK_TICKS_RST;
      cfg.boot_ticks    <= plk_pkg::BOOT_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        plk_pkg::REG_PIN_CODE:      cfg.pin_code      <= cfg_data;
        plk_pkg::REG_FAILURE_LIMIT: cfg.failure_limit <= cfg_data[3:0];
        plk_pkg::REG_LOCK_TICKS:    cfg.lock_ticks    <= cfg_data;
        plk_pkg::REG_BOOT_TICKS:    cfg.boot_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign boot_wr.load  = cfg_valid && (cfg_index == plk_pkg::REG_BOOT_TICKS);
  assign boot_wr.value = cfg_data;

endmodule

`default_nettype wire

// ===== sv/plk_core.sv =====
`default_nettype none

module plk_core #(
  parameter int PIN_DIGITS = plk_pkg::PIN_DIGITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire plk_pkg::in_t      in_data,
  input  wire plk_pkg::cfg_t     cfg,
  input  wire plk_pkg::boot_wr_t boot_wr,
  output logic                   s1_valid,
  input  wire logic              s1_ready,
  output plk_pkg::st1_t          s1
);

  localparam int CNT_W = $clog2(PIN_DIGITS + 1);
  localparam int IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIN_DIGITS);
  localparam logic [plk_pkg::SECS_ARG_W-1:0] ZERO_ARG = '0;

  // Input register.
  logic         s0_valid;
  plk_pkg::in_t s0_data;
  logic         rdy1;
  logic         step;

  // Lock state.
  plk_pkg::mode_e   mode, mode_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [3:0]       wrong, wrong_next;
  logic [15:0]      ticks, ticks_next;
  logic [3:0]       digits [PIN_DIGITS];

  logic [15:0]      ticks_dec;
  logic [3:0]       wrong_inc;
  logic [2:0]       note;
  logic             dig_we;
  logic [PIN_DIGITS-1:0] hit;
  logic             match;

  assign rdy1     = !s1_valid || s1_ready;
  assign in_ready = !s0_valid || rdy1;
  assign step     = s0_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_data <= in_data;
    end
  end

  // Digit i is checked against nibble PIN_DIGITS-1-i; nibbles past the code read as zero.
  for (genvar i = 0; i < PIN_DIGITS; i++) begin : g_cmp
    localparam int POS = PIN_DIGITS - 1 - i;
    if (POS < 4) begin : g_in
      assign hit[i] = (digits[i] == cfg.pin_code[POS*4 +: 4]);
    end else begin : g_out
      assign hit[i] = (digits[i] == 4'd0);
    end
  end
  assign match = &hit;

  assign ticks_dec = (ticks != 16'd0) ? ticks - 16'd1 : ticks;
  assign wrong_inc = (wrong != plk_pkg::WRONG_MAX) ? wrong + 4'd1 : wrong;

  always_comb begin
    mode_next  = mode;
    cnt_next   = cnt;
    wrong_next = wrong;
    ticks_next = ticks;
    note       = plk_pkg::NOTE_NONE;
    dig_we     = 1'b0;
    if (step) begin
      if (s0_data.cmd == plk_pkg::CMD_TICK) begin
        if (mode == plk_pkg::MODE_BOOT || mode == plk_pkg::MODE_LOCKED) begin
          ticks_next = ticks_dec;
          if (ticks_dec == 16'd0) begin
            if (mode == plk_pkg::MODE_LOCKED) begin
              wrong_next = 4'd0;
            end
            mode_next = plk_pkg::MODE_LOGIN;
            cnt_next  = '0;
          end
        end
      end else if (mode == plk_pkg::MODE_LOGIN) begin
        unique case (s0_data.cmd)
          plk_pkg::CMD_DIGIT: begin
            if (cnt < CNT_FULL) begin
              dig_we   = 1'b1;
              cnt_next = cnt + CNT_W'(1);
              note     = plk_pkg::NOTE_DIGIT;
            end
          end
          plk_pkg::CMD_CLEAR: begin
            cnt_next = '0;
            note     = plk_pkg::NOTE_CLEAR;
          end
          plk_pkg::CMD_ENTER: begin
            priority if (cnt < CNT_FULL) begin
              note = plk_pkg::NOTE_NEED;
            end else if (match) begin
              mode_next  = plk_pkg::MODE_OPEN;
              cnt_next   = '0;
              wrong_next = 4'd0;
              note       = plk_pkg::NOTE_OK;
            end else begin
              cnt_next   = '0;
              wrong_next = wrong_inc;
              if (wrong_inc >= cfg.failure_limit) begin
                mode_next  = plk_pkg::MODE_LOCKED;
                ticks_next = cfg.lock_ticks;
                note       = plk_pkg::NOTE_LOCKED;
              end else begin
                note = plk_pkg::NOTE_WRONG;
              end
            end
          end
          default: ;
        endcase
      end
    end
    // A boot delay write reloads the countdown while still booting.
    if (boot_wr.load && mode == plk_pkg::MODE_BOOT) begin
      ticks_next = boot_wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= plk_pkg::MODE_BOOT;
      cnt   <= '0;
      wrong <= 4'd0;
      ticks <= plk_pkg::BOOT_TICKS_RST;
    end else begin
      mode  <= mode_next;
      cnt   <= cnt_next;
      wrong <= wrong_next;
      ticks <= ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      digits[cnt[IDX_W-1:0]] <= s0_data.digit;
    end
  end

  // Result register ahead of the seconds conversion.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1.mode          <= mode_next;
      s1.entered_count <= 3'(cnt_next);
      s1.failure_count <= wrong_next;
      s1.note          <= note;
      s1.secs_arg      <= (mode_next == plk_pkg::MODE_LOCKED)
                          ? {1'b0, ticks_next} + plk_pkg::SECS_ARG_W'(0)
                          : ZERO_ARG;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("digit count above the PIN length");

  a_open_sticks: assert property (@(posedge clk) disable iff (rst)
    mode == plk_pkg::MODE_OPEN |=> mode == plk_pkg::MODE_OPEN)
    else $error("left the unlocked mode");

  a_key_outside_login: assert property (@(posedge clk) disable iff (rst)
    step && s0_data.cmd != plk_pkg::CMD_TICK && mode != plk_pkg::MODE_LOGIN
    |=> s1.note == plk_pkg::NOTE_NONE && $stable(cnt))
    else $error("key acted outside login");

endmodule

`default_nettype wire

// ===== sv/plk_secs.sv =====
`default_nettype none

module plk_secs #(
  parameter int TICKS_PER_SECOND = plk_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s1_valid,
  output logic                s1_ready,
  input  wire plk_pkg::st1_t  s1,
  output logic                out_valid,
  input  wire logic           out_ready,
  output plk_pkg::out_t       out_data
);

  localparam int ARG_W   = plk_pkg::SECS_ARG_W;
  localparam int TPS_LOG = $clog2(TICKS_PER_SECOND);
  localparam int SHIFT   = ARG_W + TPS_LOG;
  // Reciprocal, rounded up; exact floor division for any ARG_W-bit numerator.
  localparam longint unsigned MULT_VAL =
    ((64'd1 << SHIFT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam int MW   = $clog2(MULT_VAL + 1);
  localparam int PW   = ARG_W + MW;
  localparam int Q_W  = PW - SHIFT;
  localparam logic [MW-1:0]  MULT    = MW'(MULT_VAL);
  localparam logic [ARG_W-1:0] ROUND = ARG_W'(TICKS_PER_SECOND - 1);
  localparam logic [Q_W-1:0] SAT_MAX = Q_W'(127);

  logic             rdy2;
  logic [1:0]       mode;
  logic [2:0]       entered_count;
  logic [3:0]       failure_count;
  logic [2:0]       note;
  logic [PW-1:0]    product;
  logic [Q_W-1:0]   quot;

  assign rdy2     = !out_valid || out_ready;
  assign s1_ready = rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= s1_valid;
    end
  end

  // Ceiling division: (ticks + TPS - 1) times the reciprocal; zero stays zero.
  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      mode          <= s1.mode;
      entered_count <= s1.entered_count;
      failure_count <= s1.failure_count;
      note          <= s1.note;
      product       <= (s1.secs_arg == '0) ? '0
                       : PW'(s1.secs_arg + ROUND) * PW'(MULT);
    end
  end

  assign quot = product[PW-1:SHIFT];

  assign out_data.mode          = mode;
  assign out_data.entered_count = entered_count;
  assign out_data.failure_count = failure_count;
  assign out_data.note          = note;
  assign out_data.seconds_left  = (quot > SAT_MAX) ? 7'd127 : 7'(quot);

  a_secs_only_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.seconds_left != 7'd0
    |-> out_data.mode == plk_pkg::MODE_LOCKED)
    else $error("seconds shown outside lockout");

  a_note_locks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.note == plk_pkg::NOTE_LOCKED
    |-> out_data.mode == plk_pkg::MODE_LOCKED)
    else $error("locked note without lockout mode");

  a_ok_unlocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.note == plk_pkg::NOTE_OK
    |-> out_data.mode == plk_pkg::MODE_OPEN && out_data.failure_count == 4'd0)
    else $error("success note without unlock");

endmodule

`default_nettype wire

// ===== bench/lock_monitor.sv =====
`timescale 1ns / 1ps

module lock_monitor (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  plk_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  plk_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output int            errors,
  output int            pending
);

  localparam int NDIG  = plk_pkg::PIN_DIGITS_DEF;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int TPS   = plk_pkg::TICKS_PER_SECOND_DEF;
  localparam int MAX_REPORTS = 40;

  logic [15:0] pin_q;
  logic [3:0]  limit_q;
  logic [15:0] lock_q;
  logic [15:0] boot_q;

  plk_pkg::mode_e mode_q;
  logic [3:0]     keys_q [NDIG];
  logic [2:0]     held_q;
  logic [3:0]     wrong_q;
  logic [15:0]    ticks_q;

  // Lock status that each accepted key or tick should produce, oldest first.
  plk_pkg::out_t status_q [$];

  task automatic apply_item(input plk_pkg::in_t item, output plk_pkg::out_t res);
    logic [2:0] note;
    bit         hit;
    int         secs;
    int         pos;
    logic [3:0] want;
    note  = plk_pkg::NOTE_NONE;
    secs  = 0;
    if (item.cmd == plk_pkg::CMD_TICK) begin
      if (mode_q == plk_pkg::MODE_BOOT || mode_q == plk_pkg::MODE_LOCKED) begin
        if (ticks_q != 16'd0) ticks_q = ticks_q - 16'd1;
        if (ticks_q == 16'd0) begin
          if (mode_q == plk_pkg::MODE_LOCKED) wrong_q = 4'd0;
          mode_q = plk_pkg::MODE_LOGIN;
          held_q = 3'd0;
        end
      end
    end else if (mode_q == plk_pkg::MODE_LOGIN) begin
      case (item.cmd)
        plk_pkg::CMD_DIGIT: begin
          // A digit beyond the PIN length changes nothing.
          if (int'(held_q) < NDIG) begin
            keys_q[held_q[IDX_W-1:0]] = item.digit;
            held_q = held_q + 3'd1;
            note = plk_pkg::NOTE_DIGIT;
          end
        end
        plk_pkg::CMD_CLEAR: begin
          held_q = 3'd0;
          note = plk_pkg::NOTE_CLEAR;
        end
        default: begin
          if (int'(held_q) < NDIG) begin
            note = plk_pkg::NOTE_NEED;
          end else begin
            hit = 1'b1;
            for (int i = 0; i < NDIG; i++) begin
              pos = NDIG - 1 - i;
              want = (pos < 4) ? pin_q[pos*4 +: 4] : 4'd0;
              if (keys_q[i] != want) hit = 1'b0;
            end
            held_q = 3'd0;
            if (hit) begin
              mode_q = plk_pkg::MODE_OPEN;
              wrong_q = 4'd0;
              note = plk_pkg::NOTE_OK;
            end else begin
              if (wrong_q != plk_pkg::WRONG_MAX) wrong_q = wrong_q + 4'd1;
              if (wrong_q >= limit_q) begin
                mode_q = plk_pkg::MODE_LOCKED;
                ticks_q = lock_q;
                note = plk_pkg::NOTE_LOCKED;
              end else begin
                note = plk_pkg::NOTE_WRONG;
              end
            end
          end
        end
      endcase
    end
    if (mode_q == plk_pkg::MODE_LOCKED) begin
      secs = (int'(ticks_q) + TPS - 1) / TPS;
      if (secs > 127) secs = 127;
    end
    res.mode          = mode_q;
    res.entered_count = held_q;
    res.failure_count = wrong_q;
    res.note          = note;
    res.seconds_left  = 7'(secs);
  endtask

  always @(posedge clk) begin : watch
    plk_pkg::out_t want;
    if (rst) begin
      pin_q   = plk_pkg::PIN_CODE_RST;
      limit_q = plk_pkg::FAILURE_LIMIT_RST;
      lock_q  = plk_pkg::LOCK_TICKS_RST;
      boot_q  = plk_pkg::BOOT_TICKS_RST;
      mode_q  = plk_pkg::MODE_BOOT;
      held_q  = 3'd0;
      wrong_q = 4'd0;
      ticks_q = plk_pkg::BOOT_TICKS_RST;
      for (int i = 0; i < NDIG; i++) keys_q[i] = 4'd0;
      status_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          plk_pkg::REG_PIN_CODE:      pin_q = cfg_data;
          plk_pkg::REG_FAILURE_LIMIT: limit_q = cfg_data[3:0];
          plk_pkg::REG_LOCK_TICKS:    lock_q = cfg_data;
          default: begin
            boot_q = cfg_data;
            if (mode_q == plk_pkg::MODE_BOOT) ticks_q = boot_q;
          end
        endcase
      end
      // Results are matched before the new transaction is queued, since the
      // pipeline never returns a result in the cycle its input arrives.
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected result %0d/%0d/%0d/%0d/%0d",
                     $time, out_data.mode, out_data.entered_count, out_data.failure_count,
                     out_data.note, out_data.seconds_left);
        end else begin
          want = status_q.pop_front();
          if (out_data !== want) begin
            errors <= errors + 1;
            if (errors < MAX_REPORTS)
              $display("%0t: mismatch expected %0d/%0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d/%0d",
                       $time, want.mode, want.entered_count, want.failure_count, want.note,
                       want.seconds_left, out_data.mode, out_data.entered_count,
                       out_data.failure_count, out_data.note, out_data.seconds_left);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_item(in_data, want);
        status_q.push_back(want);
      end
      pending <= status_q.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT       = 200000;
  localparam int ITEM_TARGET = 810;
  localparam int LONG_HOLD   = 80;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  plk_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          cfg_valid = 1'b0;
  logic [1:0]    cfg_index = 2'd0;
  logic [15:0]   cfg_data  = 16'd0;
  logic          in_ready;
  logic          out_valid;
  logic          cfg_ready;
  plk_pkg::out_t out_data;

  int errors;
  int pending;

  // Receiver side stall control.
  bit quiet      = 1'b0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int stall_left = 0;

  // Sender side state.
  bit          no_gap    = 1'b0;
  logic [3:0]  forbidden = 4'd0;
  logic [15:0] cur_lock  = 16'd0;
  int          cycles    = 0;
  int          sent      = 0;

  always #5 clk = ~clk;

  pin_entry_lockout_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lock_monitor mon (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      stall_left <= LONG_HOLD - 1;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offers one key or tick and waits until the transaction is taken.
  task automatic push_key(input logic [1:0] cmd, input logic [3:0] dig);
    int           gap;
    plk_pkg::in_t item;
    item.cmd   = cmd;
    item.digit = dig;
    sent++;
    if (!quiet && !no_gap && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Register writes wait for the pipeline to empty.
  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // The forbidden value sits in at least one PIN nibble, so random entries never unlock.
  function automatic logic [3:0] pick_digit();
    logic [3:0] d;
    do d = 4'($urandom_range(0, 15)); while (d == forbidden);
    return d;
  endfunction

  task automatic tick();
    push_key(plk_pkg::CMD_TICK, 4'($urandom));
  endtask

  task automatic enter();
    push_key(plk_pkg::CMD_ENTER, 4'($urandom));
  endtask

  task automatic run_phase(input int k);
    logic [15:0] pin;
    logic [3:0]  limit;
    logic [15:0] boot;
    logic [1:0]  cmd;
    int          pos;
    if (k == 0) begin
      forbidden = 4'h0;
      pin = 16'h0000;
    end else if (k == 1) begin
      forbidden = 4'hF;
      pin = 16'hFFFF;
    end else begin
      forbidden = 4'($urandom_range(0, 15));
      pin = 16'($urandom);
      pos = $urandom_range(0, 3);
      pin[pos*4 +: 4] = forbidden;
    end
    case (k)
      1:       limit = 4'd15;
      2:       limit = 4'd0;
      4:       limit = 4'd1;
      default: limit = 4'($urandom_range(1, 5));
    endcase
    case (k)
      3:       cur_lock = 16'd0;
      5:       cur_lock = 16'd1;
      default: cur_lock = 16'($urandom_range(1, 40));
    endcase
    case (k)
      0:       boot = 16'h0000;
      1:       boot = 16'hFFFF;
      default: boot = 16'($urandom);
    endcase
    set_reg(plk_pkg::REG_PIN_CODE, pin);
    set_reg(plk_pkg::REG_FAILURE_LIMIT, {12'd0, limit});
    set_reg(plk_pkg::REG_LOCK_TICKS, cur_lock);
    set_reg(plk_pkg::REG_BOOT_TICKS, boot);
    if (k == 2) begin
      // Results are held back while keys keep coming, so the block backs up.
      hold_req <= hold_req + 1;
      no_gap = 1'b1;
    end
    for (int a = 0; a < 10; a++) begin
      if (a == 4) no_gap = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat (4) push_key(plk_pkg::CMD_DIGIT, pick_digit());
          enter();
        end
        6: begin
          repeat ($urandom_range(0, 3)) push_key(plk_pkg::CMD_DIGIT, pick_digit());
          enter();
        end
        7: begin
          repeat ($urandom_range(5, 6)) push_key(plk_pkg::CMD_DIGIT, pick_digit());
          enter();
        end
        8: begin
          repeat (2) push_key(plk_pkg::CMD_DIGIT, pick_digit());
          push_key(plk_pkg::CMD_CLEAR, 4'($urandom));
          repeat (4) push_key(plk_pkg::CMD_DIGIT, pick_digit());
          enter();
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            cmd = 2'($urandom_range(0, 3));
            push_key(cmd, (cmd == plk_pkg::CMD_DIGIT) ? pick_digit() : 4'($urandom));
          end
        end
      endcase
      repeat ($urandom_range(0, 2)) tick();
      if ($urandom_range(0, 2) == 0) repeat (int'(cur_lock) + 1) tick();
    end
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Boot: the default countdown runs and keys are ignored.
    tick();
    push_key(plk_pkg::CMD_DIGIT, 4'd5);
    enter();
    // A boot delay write reloads the countdown; zero lets the next tick open login.
    set_reg(plk_pkg::REG_BOOT_TICKS, 16'd3);
    tick();
    tick();
    set_reg(plk_pkg::REG_BOOT_TICKS, 16'd0);
    tick();

    // Default PIN: short entries, an extra digit, a near miss and a clear.
    enter();
    push_key(plk_pkg::CMD_DIGIT, 4'd1);
    push_key(plk_pkg::CMD_DIGIT, 4'd2);
    push_key(plk_pkg::CMD_DIGIT, 4'd3);
    enter();
    push_key(plk_pkg::CMD_DIGIT, 4'd5);
    push_key(plk_pkg::CMD_DIGIT, 4'd7);
    enter();
    push_key(plk_pkg::CMD_CLEAR, 4'd0);

    // A zero limit locks on the first miss, and a zero length ends at the next tick.
    set_reg(plk_pkg::REG_FAILURE_LIMIT, 16'd0);
    set_reg(plk_pkg::REG_LOCK_TICKS, 16'd0);
    push_key(plk_pkg::CMD_DIGIT, 4'd4);
    push_key(plk_pkg::CMD_DIGIT, 4'd3);
    push_key(plk_pkg::CMD_DIGIT, 4'd2);
    push_key(plk_pkg::CMD_DIGIT, 4'd1);
    enter();
    tick();

    // Digits above nine, and a short lockout counting down to login.
    set_reg(plk_pkg::REG_PIN_CODE, 16'hFA09);
    set_reg(plk_pkg::REG_FAILURE_LIMIT, 16'd1);
    set_reg(plk_pkg::REG_LOCK_TICKS, 16'd2);
    push_key(plk_pkg::CMD_DIGIT, 4'hF);
    push_key(plk_pkg::CMD_DIGIT, 4'hA);
    push_key(plk_pkg::CMD_DIGIT, 4'h0);
    push_key(plk_pkg::CMD_DIGIT, 4'h8);
    enter();
    push_key(plk_pkg::CMD_DIGIT, 4'h9);
    tick();
    tick();

    k = 0;
    while (k < 6 || sent < ITEM_TARGET) begin
      run_phase(k);
      k++;
    end

    // Closing part without idling: a lockout, then the one unlock.
    quiet <= 1'b1;
    set_reg(plk_pkg::REG_PIN_CODE, 16'h9F05);
    set_reg(plk_pkg::REG_FAILURE_LIMIT, 16'd1);
    set_reg(plk_pkg::REG_LOCK_TICKS, 16'd30);
    set_reg(plk_pkg::REG_BOOT_TICKS, 16'h1234);
    repeat (41) tick();
    push_key(plk_pkg::CMD_CLEAR, 4'd0);
    repeat (4) push_key(plk_pkg::CMD_DIGIT, 4'd0);
    enter();
    repeat (30) tick();
    push_key(plk_pkg::CMD_DIGIT, 4'h9);
    push_key(plk_pkg::CMD_DIGIT, 4'hF);
    push_key(plk_pkg::CMD_DIGIT, 4'h0);
    push_key(plk_pkg::CMD_DIGIT, 4'h5);
    enter();
    // Once open, everything is ignored.
    tick();
    push_key(plk_pkg::CMD_DIGIT, 4'd3);
    push_key(plk_pkg::CMD_CLEAR, 4'd0);
    enter();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
